FILE: design/lpht_pkg.sv
// lpht_pkg: shared types and constants for the linear probe hash table
// no dependencies; used by lpht_engine and linear_probe_hash_table
package lpht_pkg;

    localparam int KEY_W        = 32;
    localparam int LIMIT_W      = 13;
    localparam int SLOT_W       = 12;
    localparam int PROBE_W      = 13;
    localparam int TABLE_SIZE_DEF = 4096;

    localparam logic [KEY_W-1:0]   EMPTY_KEY   = 32'hFFFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd32;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISS    = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BAD_KEY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } state_t;

    // finished operation, one cycle wide
    typedef struct packed {
        logic                done;
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [PROBE_W-1:0]  probes;
        logic                hit;
    } res_t;

endpackage

FILE: design/lpht_ram.sv
// lpht_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lpht_engine.sv
// lpht_engine: probe sequencer with the slot memory and one shared key compare
// depends on lpht_pkg and lpht_ram
module lpht_engine #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          mode,
    input  logic [lpht_pkg::KEY_W-1:0]    key,
    input  logic [lpht_pkg::LIMIT_W-1:0]  probe_limit,
    output logic                          busy,
    output lpht_pkg::res_t                res
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SIZE);

    lpht_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    lim_reg, lim_next;
    logic [lpht_pkg::KEY_W-1:0] key_reg, key_next;
    logic             mode_reg, mode_next;

    logic                       we;
    logic [IW-1:0]              waddr;
    logic [lpht_pkg::KEY_W-1:0] wdata;
    logic [lpht_pkg::KEY_W-1:0] rdata;

    logic [31:0]   lim_wide;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cap;
    logic          slot_empty;
    logic          slot_match;

    lpht_ram #(
        .WIDTH (lpht_pkg::KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_next),
        .rdata (rdata)
    );

    // effective lookup limit, clamped to 1..TABLE_SIZE
    always_comb
    begin
        lim_wide = 32'(probe_limit);
        if (lim_wide == 32'd0)
        begin
            lim_wide = 32'd1;
        end
        else if (lim_wide > 32'(TABLE_SIZE))
        begin
            lim_wide = 32'(TABLE_SIZE);
        end
    end

    assign cnt_inc    = cnt_reg + 1'b1;
    assign cap        = mode_reg ? FULL_CNT : lim_reg;
    assign slot_empty = (rdata == lpht_pkg::EMPTY_KEY);
    assign slot_match = (rdata == key_reg);
    assign busy       = (state_reg != lpht_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::S_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        lim_reg  <= lim_next;
        key_reg  <= key_next;
        mode_reg <= mode_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        lim_next   = lim_reg;
        key_next   = key_reg;
        mode_next  = mode_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = key_reg;
        res        = '0;
        res.status = lpht_pkg::STAT_MISS;

        case (state_reg)
            lpht_pkg::S_CLEAR:
            begin
                // sweep every slot to the empty marker
                we       = 1'b1;
                wdata    = lpht_pkg::EMPTY_KEY;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == '1)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (mode && (key == lpht_pkg::EMPTY_KEY))
                    begin
                        res.done   = 1'b1;
                        res.status = lpht_pkg::STAT_BAD_KEY;
                    end
                    else
                    begin
                        key_next   = key;
                        mode_next  = mode;
                        idx_next   = key[IW-1:0];
                        cnt_next   = '0;
                        lim_next   = CW'(lim_wide);
                        state_next = lpht_pkg::S_CHECK;
                    end
                end
            end
            lpht_pkg::S_CHECK:
            begin
                if (slot_empty)
                begin
                    res.done   = 1'b1;
                    res.probes = lpht_pkg::PROBE_W'(cnt_inc);
                    state_next = lpht_pkg::S_IDLE;
                    if (mode_reg)
                    begin
                        we         = 1'b1;
                        res.status = lpht_pkg::STAT_OK;
                        res.slot   = lpht_pkg::SLOT_W'(idx_reg);
                    end
                end
                else if (slot_match && !mode_reg)
                begin
                    res.done   = 1'b1;
                    res.hit    = 1'b1;
                    res.status = lpht_pkg::STAT_OK;
                    res.slot   = lpht_pkg::SLOT_W'(idx_reg);
                    res.probes = lpht_pkg::PROBE_W'(cnt_inc);
                    state_next = lpht_pkg::S_IDLE;
                end
                else if (cnt_inc == cap)
                begin
                    res.done   = 1'b1;
                    res.status = mode_reg ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_MISS;
                    res.probes = lpht_pkg::PROBE_W'(cnt_inc);
                    state_next = lpht_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == lpht_pkg::S_CLEAR || state_reg == lpht_pkg::S_CHECK))
        else $error("slot write outside clear or probe");

    a_lookup_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_CHECK && !mode_reg) |-> (cnt_reg < lim_reg))
        else $error("lookup ran past its probe limit");

    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_CLEAR) |-> !res.done)
        else $error("result during clearing pass");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |=> (state_reg == lpht_pkg::S_IDLE))
        else $error("sequencer not idle after result");

endmodule

FILE: design/linear_probe_hash_table.sv
// linear_probe_hash_table: top level, config register, hit counter, result registers
// depends on lpht_pkg and lpht_engine (which holds lpht_ram)
//
// open-addressing table of 32-bit keys with linear probing and wrap. the home
// slot is the low key bits. after reset the block runs a clearing pass over all
// TABLE_SIZE slots (4096 by default) with busy high, writing the empty marker
// (all ones) into every slot; config writes are still taken then. a command is
// taken on a cycle with start high and busy low. the slot memory is read once
// per cycle; an operation keeps busy high while it examines slots (probes), and
// its result word shows on the result ports, registered, with done high for one
// cycle. a new command may start in the cycle the result is shown. an insert of
// the empty marker is rejected at once (status 3, probes 0) and never raises
// busy. the receiver cannot hold off a result: capture it in the done cycle.
// hit_count is the running lookup hit total, saturating, and is valid as the
// count after the shown operation. the user must write probe_limit over
// cfg_valid/cfg_ready only while no command is in flight; the block itself does
// not enforce this. 0 acts as 1 and values above TABLE_SIZE act as TABLE_SIZE
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [lpht_pkg::KEY_W-1:0]    key,
    // result side
    output logic                          done,
    output logic [1:0]                    status,
    output logic [lpht_pkg::SLOT_W-1:0]   slot,
    output logic [lpht_pkg::PROBE_W-1:0]  probes,
    output logic [lpht_pkg::KEY_W-1:0]    hit_count,
    // probe limit write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpht_pkg::LIMIT_W-1:0]  cfg_data
);

    lpht_pkg::res_t res;

    logic [lpht_pkg::LIMIT_W-1:0] probe_limit_reg;
    logic                         done_reg;
    lpht_pkg::status_t            status_reg;
    logic [lpht_pkg::SLOT_W-1:0]  slot_reg;
    logic [lpht_pkg::PROBE_W-1:0] probes_reg;
    logic [lpht_pkg::KEY_W-1:0]   hits_reg, hits_next;

    // probe sequencer with the slot memory
    lpht_engine #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .key         (key),
        .probe_limit (probe_limit_reg),
        .busy        (busy),
        .res         (res)
    );

    // config is always accepted
    assign cfg_ready = 1'b1;

    // saturating lookup hit count
    always_comb
    begin
        hits_next = hits_reg;
        if (res.hit && (hits_reg != '1))
        begin
            hits_next = hits_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_limit_reg <= lpht_pkg::LIMIT_RESET;
            done_reg        <= 1'b0;
            hits_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                probe_limit_reg <= cfg_data;
            end
            done_reg <= res.done;
            hits_reg <= hits_next;
        end
    end

    // result word, loaded only when an operation finishes
    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            status_reg <= res.status;
            slot_reg   <= res.slot;
            probes_reg <= res.probes;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign probes    = probes_reg;
    assign hit_count = hits_reg;

endmodule

FILE: test/tb_linear_probe_hash_table.sv
`timescale 1ns / 100ps
// tb_linear_probe_hash_table: self-checking bench for the linear probe hash table
// holds a scoreboard class that mirrors the slot table, then drives and checks the dut
// depends on lpht_pkg and linear_probe_hash_table

localparam int  TABLE_SLOTS = lpht_pkg::TABLE_SIZE_DEF;
localparam logic OP_LOOKUP  = 1'b0;
localparam logic OP_INSERT  = 1'b1;

typedef struct {
    lpht_pkg::status_t                status;
    logic [lpht_pkg::SLOT_W-1:0]      slot;
    logic [lpht_pkg::PROBE_W-1:0]     probes;
    logic [lpht_pkg::KEY_W-1:0]       hits;
} op_word_t;

class lpht_scoreboard;
    logic [lpht_pkg::KEY_W-1:0]   table_keys [TABLE_SLOTS];
    logic [lpht_pkg::KEY_W-1:0]   hit_total;
    logic [lpht_pkg::LIMIT_W-1:0] probe_limit;
    op_word_t                     pending_words [$];
    int                           errors;

    function new();
        foreach (table_keys[i])
            table_keys[i] = lpht_pkg::EMPTY_KEY;
        hit_total   = '0;
        probe_limit = lpht_pkg::LIMIT_RESET;
        errors      = 0;
    endfunction

    function void set_limit(input logic [lpht_pkg::LIMIT_W-1:0] v);
        probe_limit = v;
    endfunction

    // accepted command: walk the mirrored table and queue the word it must produce
    function void note_command(input logic op, input logic [lpht_pkg::KEY_W-1:0] k);
        op_word_t                    w;
        logic [lpht_pkg::SLOT_W-1:0] home;
        logic [lpht_pkg::SLOT_W-1:0] idx;
        int                          lim;
        int                          p;
        w.status = lpht_pkg::STAT_MISS;
        w.slot   = '0;
        w.probes = '0;
        home     = k[lpht_pkg::SLOT_W-1:0];
        if (op == OP_INSERT)
        begin
            if (k == lpht_pkg::EMPTY_KEY)
                w.status = lpht_pkg::STAT_BAD_KEY;
            else
            begin
                w.status = lpht_pkg::STAT_FULL;
                w.probes = lpht_pkg::PROBE_W'(TABLE_SLOTS);
                for (p = 0; p < TABLE_SLOTS; p++)
                begin
                    idx = home + lpht_pkg::SLOT_W'(p);
                    if (table_keys[idx] == lpht_pkg::EMPTY_KEY)
                    begin
                        table_keys[idx] = k;
                        w.status = lpht_pkg::STAT_OK;
                        w.slot   = idx;
                        w.probes = lpht_pkg::PROBE_W'(p + 1);
                        break;
                    end
                end
            end
        end
        else
        begin
            lim = int'(probe_limit);
            if (lim == 0)
                lim = 1;
            if (lim > TABLE_SLOTS)
                lim = TABLE_SLOTS;
            w.probes = lpht_pkg::PROBE_W'(lim);
            for (p = 0; p < lim; p++)
            begin
                idx = home + lpht_pkg::SLOT_W'(p);
                if (table_keys[idx] == lpht_pkg::EMPTY_KEY)
                begin
                    w.probes = lpht_pkg::PROBE_W'(p + 1);
                    break;
                end
                if (table_keys[idx] == k)
                begin
                    w.status = lpht_pkg::STAT_OK;
                    w.slot   = idx;
                    w.probes = lpht_pkg::PROBE_W'(p + 1);
                    if (hit_total != '1)
                        hit_total = hit_total + 1'b1;
                    break;
                end
            end
        end
        w.hits = hit_total;
        pending_words.push_back(w);
    endfunction

    function void check_word(input logic [1:0] st, input logic [lpht_pkg::SLOT_W-1:0] sl,
                             input logic [lpht_pkg::PROBE_W-1:0] pr,
                             input logic [lpht_pkg::KEY_W-1:0] hc);
        op_word_t w;
        if (pending_words.size() == 0)
        begin
            $display("%0t: unexpected result word, status %0d slot %0d probes %0d hits %0d",
                     $time, st, sl, pr, hc);
            errors++;
            return;
        end
        w = pending_words.pop_front();
        if (st !== w.status)
        begin
            $display("%0t: status expected %0d, got %0d", $time, w.status, st);
            errors++;
        end
        if (sl !== w.slot)
        begin
            $display("%0t: slot expected %0d, got %0d", $time, w.slot, sl);
            errors++;
        end
        if (pr !== w.probes)
        begin
            $display("%0t: probes expected %0d, got %0d", $time, w.probes, pr);
            errors++;
        end
        if (hc !== w.hits)
        begin
            $display("%0t: hit_count expected %0d, got %0d", $time, w.hits, hc);
            errors++;
        end
    endfunction
endclass

module tb_linear_probe_hash_table;

    // clearing pass plus ~1k commands, even if every one walked the whole table
    localparam int CYCLE_LIMIT = 20_000_000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          mode;
    logic [lpht_pkg::KEY_W-1:0]    key;
    logic                          done;
    logic [1:0]                    status;
    logic [lpht_pkg::SLOT_W-1:0]   slot;
    logic [lpht_pkg::PROBE_W-1:0]  probes;
    logic [lpht_pkg::KEY_W-1:0]    hit_count;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lpht_pkg::LIMIT_W-1:0]  cfg_data;

    lpht_scoreboard                board;
    logic [lpht_pkg::KEY_W-1:0]    stored_keys [$];   // keys sent as inserts, reused for hits
    logic [lpht_pkg::SLOT_W-1:0]   hot_base;          // home window that grows clusters
    int                            sender_idle_pct;
    int                            cycle_count = 0;

    linear_probe_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .key       (key),
        .done      (done),
        .status    (status),
        .slot      (slot),
        .probes    (probes),
        .hit_count (hit_count),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // monitor: values read here are the ones present just before the edge
    // config write first, then the command taken, then the result word shown;
    // a word shown at this edge always belongs to an older command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_limit(cfg_data);
            if (start && !busy)
                board.note_command(mode, key);
            if (done)
                board.check_word(status, slot, probes, hit_count);
        end
    end

    // present one command and hold it until busy is seen low at an edge,
    // then maybe leave start low for a random stretch
    task automatic send_command(input logic op, input logic [lpht_pkg::KEY_W-1:0] k);
        start <= 1'b1;
        mode  <= op;
        key   <= k;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            mode  <= 1'($urandom());
            key   <= $urandom();
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
    endtask

    // stop sending and wait until every expected word is in
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [lpht_pkg::LIMIT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // inserts and lookups, many around a hot window so chains get long,
    // with hits on stored keys, duplicates and the odd empty marker as noise
    task automatic random_item();
        int                         r;
        int                         s;
        logic [lpht_pkg::KEY_W-1:0] k;
        r = $urandom_range(99);
        s = $urandom_range(99);
        k = $urandom();
        if (r < 45)
        begin
            if (s < 40)
                k[lpht_pkg::SLOT_W-1:0] = hot_base + lpht_pkg::SLOT_W'($urandom_range(15));
            else if (s >= 80 && s < 93 && stored_keys.size() > 0)
                k = stored_keys[$urandom_range(stored_keys.size() - 1)];
            else if (s >= 93)
                k = lpht_pkg::EMPTY_KEY;
            if (k != lpht_pkg::EMPTY_KEY)
                stored_keys.push_back(k);
            send_command(OP_INSERT, k);
        end
        else
        begin
            if (s < 50 && stored_keys.size() > 0)
                k = stored_keys[$urandom_range(stored_keys.size() - 1)];
            else if (s < 80)
                k[lpht_pkg::SLOT_W-1:0] = hot_base + lpht_pkg::SLOT_W'($urandom_range(15));
            else if (s >= 95)
                k = lpht_pkg::EMPTY_KEY;
            send_command(OP_LOOKUP, k);
        end
    endtask

    initial
    begin
        int                           ph;
        int                           i;
        logic [lpht_pkg::LIMIT_W-1:0] phase_limits [8];

        board           = new();
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        mode            = OP_LOOKUP;
        key             = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        sender_idle_pct = 16;
        hot_base        = '0;
        // extremes of the limit field plus its treated cases: 0 acts as 1, above 4096 clamps
        phase_limits    = '{13'd3, 13'd32, 13'd4096, 13'd0, 13'd8191, 13'd0, 13'd1, 13'd4095};
        phase_limits[5] = lpht_pkg::LIMIT_W'($urandom_range(2, 100));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset limit; the first command waits out the clearing pass
        send_command(OP_LOOKUP, 32'h0000_0000);   // empty table, miss on first slot
        send_command(OP_INSERT, 32'hFFFF_FFFF);   // empty marker rejected
        send_command(OP_LOOKUP, 32'hFFFF_FFFF);   // empty marker lookup always misses
        send_command(OP_INSERT, 32'h0000_0000);   // home 0
        send_command(OP_INSERT, 32'h0000_1000);   // collides at home 0 -> slot 1
        send_command(OP_INSERT, 32'hFFFF_F000);   // -> slot 2
        send_command(OP_INSERT, 32'hFFFF_FFFE);   // home 4094
        send_command(OP_INSERT, 32'h7FFF_FFFF);   // last slot
        send_command(OP_INSERT, 32'h8000_0FFF);   // wraps past the end into slot 3
        send_command(OP_LOOKUP, 32'h8000_0FFF);   // hit after the wrap
        send_command(OP_LOOKUP, 32'h1234_5000);   // miss at the end of the chain
        send_command(OP_INSERT, 32'h0000_1000);   // duplicate is stored again
        send_command(OP_LOOKUP, 32'h0000_1000);   // first copy wins
        send_command(OP_LOOKUP, 32'hFFFF_FFFF);   // marker walking a wrapped chain
        send_command(OP_INSERT, 32'hFFFF_FFFF);   // back to back rejections
        send_command(OP_INSERT, 32'hFFFF_FFFF);
        send_command(OP_LOOKUP, 32'h5555_AAAA);
        send_command(OP_INSERT, 32'h5555_AAAA);
        send_command(OP_LOOKUP, 32'h5555_AAAA);
        send_command(OP_INSERT, 32'hAAAA_5555);
        send_command(OP_LOOKUP, 32'hAAAA_5555);

        // random part: eight limit settings, sender idling 16%, then 74%, then never
        for (ph = 0; ph < 8; ph++)
        begin
            write_limit(phase_limits[ph]);
            sender_idle_pct = (ph < 3) ? 16 : ((ph < 6) ? 74 : 0);
            hot_base        = lpht_pkg::SLOT_W'($urandom());
            for (i = 0; i < 119; i++)
                random_item();
        end

        // loaded table: oversized limit, then the smallest ones
        write_limit(13'd8191);
        send_command(OP_LOOKUP, 32'h0123_4567);
        send_command(OP_LOOKUP, 32'h8000_0FFF);
        send_command(OP_LOOKUP, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 32'hFFFF_FFFF);
        write_limit(13'd1);
        send_command(OP_LOOKUP, 32'h0123_4567);
        send_command(OP_LOOKUP, 32'h0000_1000);
        write_limit(13'd0);
        send_command(OP_LOOKUP, 32'hFFFF_FFFF);

        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_engine.sv
design/linear_probe_hash_table.sv
test/tb_linear_probe_hash_table.sv
